@@ hw/rtl/keyed_length_histogram_core_assert.svh @@
// Assertion macros for the keyed length histogram core.
// Included by the top level; depends on nothing else.
`ifndef KEYED_LENGTH_HISTOGRAM_CORE_ASSERT_SVH
`define KEYED_LENGTH_HISTOGRAM_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KLH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define KLH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/khist_pkg.sv @@
// Package for the keyed length histogram: payload structs, status codes,
// the token that walks the cell chain, and constants. Depends on nothing.
`default_nettype none
package khist_pkg;

   localparam int DEFAULT_TABLE_ENTRIES = 256;
   localparam int SLOT_W                = 16;
   localparam logic [31:0] BIN_LIMIT     = 32'h0000_FFFF;
   localparam logic [15:0] BIN_SATURATED = 16'hFFFE;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] CSR_BIN_WIDTH = 2'd0;

   typedef enum logic [2:0] {
      ST_ADDED    = 3'd0,
      ST_NEW      = 3'd1,
      ST_REJECTED = 3'd2,
      ST_FULL     = 3'd3,
      ST_READ_OK  = 3'd4,
      ST_EMPTY    = 3'd5
   } status_type;

   typedef struct packed {
      logic               cmd;
      logic [7:0]         mode;
      logic [7:0]         purpose_a;
      logic [7:0]         purpose_b;
      logic signed [31:0] length;
      logic signed [31:0] trip_count;
      logic [7:0]         read_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [7:0]         slot;
      logic [7:0]         entry_mode;
      logic [7:0]         purpose_low;
      logic [7:0]         purpose_high;
      logic [15:0]        length_bin;
      logic signed [31:0] total;
   } rsp_type;

   // Transaction token handed from cell to cell.
   typedef struct packed {
      logic              valid;
      logic              cmd;
      logic [39:0]       key;
      logic [31:0]       cnt;
      logic [7:0]        req_slot;
      logic              found;
      logic              is_new;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       total;
   } token_type;

endpackage
`default_nettype wire

@@ hw/rtl/khist_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its ports.
`default_nettype none
module khist_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   logic [15:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] shifted;
   logic [16:0] diff;

   always_comb begin
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quot_ff[31]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quot_in = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so 16 bits hold it.
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in  = diff[15:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in  = shifted[15:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;
endmodule
`default_nettype wire

@@ hw/rtl/khist_cell.sv @@
// One table cell: holds one entry's key and total and passes the token on.
// Depends on khist_pkg.
`default_nettype none
module khist_cell #(
   parameter int INDEX  = 0,
   parameter int USED_W = 9
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [USED_W-1:0]     used_i,
   input  wire khist_pkg::token_type  tok_i,
   output khist_pkg::token_type       tok_o
);
   import khist_pkg::*;

   localparam logic [USED_W-1:0] IDX  = USED_W'(INDEX);
   localparam logic [SLOT_W-1:0] SIDX = SLOT_W'(INDEX);

   logic [39:0] key_ff, key_in;
   logic [31:0] total_ff, total_in;
   token_type   tok_ff, tok_in;
   logic        filled, at_end;
   logic [31:0] sum;

   always_comb begin
      filled   = IDX < used_i;
      at_end   = IDX == used_i;
      sum      = total_ff + tok_i.cnt;
      key_in   = key_ff;
      total_in = total_ff;
      tok_in   = tok_i;
      if (tok_i.valid && !tok_i.found) begin
         if (tok_i.cmd == CMD_ADD) begin
            if (filled && key_ff == tok_i.key) begin
               total_in     = sum;
               tok_in.found = 1'b1;
               tok_in.slot  = SIDX;
               tok_in.total = sum;
            end else if (at_end) begin
               key_in        = tok_i.key;
               total_in      = tok_i.cnt;
               tok_in.found  = 1'b1;
               tok_in.is_new = 1'b1;
               tok_in.slot   = SIDX;
               tok_in.total  = tok_i.cnt;
            end
         end else if (filled && {8'd0, tok_i.req_slot} == SIDX) begin
            tok_in.found = 1'b1;
            tok_in.slot  = SIDX;
            tok_in.key   = key_ff;
            tok_in.total = total_ff;
         end
      end
      // Reset empties the chain.
      if (reset) begin
         tok_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      total_ff <= total_in;
      tok_ff   <= tok_in;
   end

   assign tok_o = tok_ff;
endmodule
`default_nettype wire

@@ hw/rtl/keyed_length_histogram_core.sv @@
// Top level of the keyed length histogram: APB register, input front end,
// divider and the chain of table cells. Depends on khist_pkg, khist_div, khist_cell.
//
//   channel   direction   handshake               payload
//   req       in          req_valid / req_stall   req_data (khist_pkg::req_type)
//   rsp       out         rsp_valid / rsp_stall   rsp_data (khist_pkg::rsp_type)
//   csr       in          psel / penable / pready paddr, pwdata, prdata
//
// An add transaction first passes through the divider, then its token walks
// the cell chain, handed over to it through the S_LAUNCH state.
// A read transaction skips the divider; a rejected add skips the chain.
// Reset is synchronous and empties the table by clearing the fill count.
// A stalled result holds its register; the next transaction is still taken
// and waits ahead of the chain until the result register is free.
`default_nettype none
module keyed_length_histogram_core #(
   parameter int TABLE_ENTRIES = khist_pkg::DEFAULT_TABLE_ENTRIES
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire khist_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output khist_pkg::rsp_type     rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [1:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   import khist_pkg::*;

   localparam int USED_W = $clog2(TABLE_ENTRIES + 1);

   typedef enum logic [1:0] {S_IDLE, S_DIVIDE, S_LAUNCH, S_CHAIN} state_type;

   state_type          state_ff;
   logic [15:0]        bin_width_ff;
   logic [USED_W-1:0]  used_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // Held copy of the transaction in flight.
   logic        cmd_ff, reject_ff;
   logic [7:0]  mode_ff, lo_ff, hi_ff, slot_req_ff;
   logic [31:0] cnt_ff;
   logic [15:0] bin_ff;

   logic        accept, rsp_free, div_start, div_done, launch, reject_c, rsp_load;
   logic [31:0] quotient;
   token_type   chain [TABLE_ENTRIES+1];
   token_type   last_tok;

   // The configuration port never waits.
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_BIN_WIDTH) ? {16'd0, bin_width_ff} : 32'd0;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign reject_c  = bin_width_ff == 16'd0 || req_data.length[31];
   assign div_start = accept && req_data.cmd == CMD_ADD && !reject_c;
   assign launch    = state_ff == S_LAUNCH && rsp_free && !reject_ff;

   khist_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_data.length),
      .divisor  (bin_width_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Token entering the first cell.
   always_comb begin
      chain[0]          = '0;
      chain[0].valid    = launch;
      chain[0].cmd      = cmd_ff;
      chain[0].key      = {mode_ff, lo_ff, hi_ff, bin_ff};
      chain[0].cnt      = cnt_ff;
      chain[0].req_slot = slot_req_ff;
   end

   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      khist_cell #(.INDEX(g), .USED_W(USED_W)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .used_i (used_ff),
         .tok_i  (chain[g]),
         .tok_o  (chain[g+1])
      );
   end

   assign last_tok = chain[TABLE_ENTRIES];

   // A result is loaded either for a rejected add or when the token leaves the chain.
   assign rsp_load = (state_ff == S_LAUNCH && rsp_free && reject_ff) ||
                     (state_ff == S_CHAIN && last_tok.valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bin_width_ff <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == CSR_BIN_WIDTH) begin
            bin_width_ff <= pwdata[15:0];
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cmd_ff      <= req_data.cmd;
                  reject_ff   <= req_data.cmd == CMD_ADD && reject_c;
                  mode_ff     <= req_data.mode;
                  lo_ff       <= (req_data.purpose_a < req_data.purpose_b) ?
                                 req_data.purpose_a : req_data.purpose_b;
                  hi_ff       <= (req_data.purpose_a < req_data.purpose_b) ?
                                 req_data.purpose_b : req_data.purpose_a;
                  cnt_ff      <= req_data.trip_count;
                  slot_req_ff <= req_data.read_slot;
                  bin_ff      <= '0;
                  state_ff    <= div_start ? S_DIVIDE : S_LAUNCH;
               end
            end
            S_DIVIDE: begin
               if (div_done) begin
                  bin_ff   <= (quotient >= BIN_LIMIT) ? BIN_SATURATED : quotient[15:0];
                  state_ff <= S_LAUNCH;
               end
            end
            S_LAUNCH: begin
               if (rsp_free) begin
                  if (reject_ff) begin
                     rsp_ff   <= '{status: ST_REJECTED, default: '0};
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_CHAIN;
                  end
               end
            end
            S_CHAIN: begin
               if (last_tok.valid) begin
                  if (last_tok.cmd == CMD_READ) begin
                     if (last_tok.found) begin
                        rsp_ff.status       <= ST_READ_OK;
                        rsp_ff.slot         <= last_tok.slot[7:0];
                        rsp_ff.entry_mode   <= last_tok.key[39:32];
                        rsp_ff.purpose_low  <= last_tok.key[31:24];
                        rsp_ff.purpose_high <= last_tok.key[23:16];
                        rsp_ff.length_bin   <= last_tok.key[15:0];
                        rsp_ff.total        <= last_tok.total;
                     end else begin
                        rsp_ff <= '{status: ST_EMPTY, slot: last_tok.req_slot,
                                    default: '0};
                     end
                  end else begin
                     rsp_ff.entry_mode   <= last_tok.key[39:32];
                     rsp_ff.purpose_low  <= last_tok.key[31:24];
                     rsp_ff.purpose_high <= last_tok.key[23:16];
                     rsp_ff.length_bin   <= last_tok.key[15:0];
                     if (last_tok.found) begin
                        rsp_ff.status <= last_tok.is_new ? ST_NEW : ST_ADDED;
                        rsp_ff.slot   <= last_tok.slot[7:0];
                        rsp_ff.total  <= last_tok.total;
                        if (last_tok.is_new) begin
                           used_ff <= used_ff + USED_W'(1);
                        end
                     end else begin
                        rsp_ff.status <= ST_FULL;
                        rsp_ff.slot   <= '0;
                        rsp_ff.total  <= '0;
                     end
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "keyed_length_histogram_core_assert.svh"

   // An accepted transaction makes the block busy in the next cycle.
   `KLH_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, req_stall)
   // A token leaves the chain only while one is expected.
   `KLH_ASSERT_NOW(a_exit_in_chain, clock, reset, last_tok.valid, state_ff == S_CHAIN)
   // The fill count never passes the table size.
   `KLH_ASSERT_NOW(a_used_bound, clock, reset, 1'b1, used_ff <= USED_W'(TABLE_ENTRIES))
   // A new entry raises the fill count by exactly one.
   `KLH_ASSERT_NEXT(a_used_step, clock, reset,
      state_ff == S_CHAIN && last_tok.valid && last_tok.found && last_tok.is_new,
      used_ff == $past(used_ff) + USED_W'(1))

endmodule
`default_nettype wire
